// ----- rtl/core/imm_pkg.sv -----
// shared types, constants and a size-clamping helper for the integer matrix multiply block
`timescale 1ns / 1ps
`default_nettype none

package imm_pkg;

	localparam int MAX_ROWS_DEF   = 8;
	localparam int MAX_INNER_DEF  = 8;
	localparam int MAX_COLS_DEF   = 8;
	localparam int ELEM_WIDTH_DEF = 32;

	localparam int OP_W    = 2;
	localparam int IDX_W   = 6;
	localparam int VAL_W   = 32;
	localparam int ROW_W   = 3;
	localparam int COL_W   = 3;
	localparam int SIZE_W  = 4;
	localparam int CNT_W   = 2 * SIZE_W;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 40;

	localparam int IDX_SPACE = 2 ** IDX_W;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD_A = 2'd0,
		OP_LOAD_B = 2'd1,
		OP_START  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	localparam logic [1:0] REG_ROWS  = 2'd0;
	localparam logic [1:0] REG_INNER = 2'd1;
	localparam logic [1:0] REG_COLS  = 2'd2;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_ctl_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v, input int maxv);
		logic [SIZE_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (int'(v) > maxv) begin
			r = SIZE_W'(maxv);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/imm_mac.sv -----
// multiply-accumulate pipeline: registered product, then running sum
`timescale 1ns / 1ps
`default_nettype none

module imm_mac #(
	parameter int ELEM_WIDTH = imm_pkg::ELEM_WIDTH_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire imm_pkg::mac_ctl_t ctl_s1,
	input  wire [ELEM_WIDTH-1:0] a_s1,
	input  wire [ELEM_WIDTH-1:0] b_s1,
	output logic [ELEM_WIDTH-1:0] acc,
	output logic                  done
);
	import imm_pkg::*;

	mac_ctl_t              ctl_s2;
	logic [ELEM_WIDTH-1:0] prod_s2;
	logic [ELEM_WIDTH-1:0] acc_q;
	logic                  done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s2 <= ctl_s1;
			done_q <= ctl_s2.valid && ctl_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			prod_s2 <= a_s1 * b_s1;
		end
		if (ctl_s2.valid) begin
			acc_q <= ctl_s2.first ? prod_s2 : acc_q + prod_s2;
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

`default_nettype wire

// ----- rtl/core/integer_matrix_multiply.sv -----
// top level: element stores, result sequencer, stream and register ports
`timescale 1ns / 1ps
`default_nettype none

// Integer matrix multiply. Load items (tuser 0 for A, 1 for B) write one element
// at its row-major index and are accepted back to back while idle; indexes outside
// the configured size are dropped. A start item (tuser 2) computes C = A * B and
// sends rows_m * cols_p results in row-major order, tlast on the final one. For
// each result one multiply-accumulate unit reads one A and one B element per cycle
// from the two stores, followed by read, multiply and accumulate stages. Input is
// held off from the start item until the final result sits in the output register.
// Sums wrap modulo 2^ELEM_WIDTH. Store entries never written read as undefined.
module integer_matrix_multiply #(
	parameter int MAX_ROWS   = imm_pkg::MAX_ROWS_DEF,
	parameter int MAX_INNER  = imm_pkg::MAX_INNER_DEF,
	parameter int MAX_COLS   = imm_pkg::MAX_COLS_DEF,
	parameter int ELEM_WIDTH = imm_pkg::ELEM_WIDTH_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           s_axis_tvalid,
	output logic                          s_axis_tready,
	// element_index, element_value, zero pad
	input  wire [imm_pkg::S_DATA_W-1:0]   s_axis_tdata,
	// operation
	input  wire [imm_pkg::OP_W-1:0]       s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  wire                           m_axis_tready,
	// product_value, product_row, product_col, zero pad
	output logic [imm_pkg::M_DATA_W-1:0]  m_axis_tdata,
	output logic                          m_axis_tlast,
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire [imm_pkg::PADDR_W-1:0]    paddr,
	input  wire [imm_pkg::PDATA_W-1:0]    pwdata,
	output logic [imm_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import imm_pkg::*;

	localparam int DEPTH_A = (MAX_ROWS * MAX_INNER < IDX_SPACE) ? MAX_ROWS * MAX_INNER : IDX_SPACE;
	localparam int DEPTH_B = (MAX_INNER * MAX_COLS < IDX_SPACE) ? MAX_INNER * MAX_COLS : IDX_SPACE;
	localparam int AW_A    = (DEPTH_A > 1) ? $clog2(DEPTH_A) : 1;
	localparam int AW_B    = (DEPTH_B > 1) ? $clog2(DEPTH_B) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HOLD,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	state_t state_q;

	logic [SIZE_W-1:0] rows_q, inner_q, cols_q;
	logic [SIZE_W-1:0] m_eff, n_eff, p_eff;
	logic [CNT_W-1:0]  size_a, size_b;

	op_t               in_op;
	logic [IDX_W-1:0]  in_idx;
	logic [VAL_W-1:0]  in_val;
	logic              in_xfer;
	logic              load_a_ok, load_b_ok;

	logic [ELEM_WIDTH-1:0] mem_a [DEPTH_A];
	logic [ELEM_WIDTH-1:0] mem_b [DEPTH_B];
	logic [ELEM_WIDTH-1:0] a_rd_s1, b_rd_s1;
	mac_ctl_t              ctl_s1;

	logic [SIZE_W-1:0] i_q, j_q, k_q;
	logic [CNT_W-1:0]  a_base_q, a_addr_q, b_addr_q;
	logic              k_last, j_last, i_last;

	logic [ELEM_WIDTH-1:0] mac_acc;
	logic                  mac_done;

	logic                  out_valid_q;
	logic [ELEM_WIDTH-1:0] out_value_q;
	logic [ROW_W-1:0]      out_row_q;
	logic [COL_W-1:0]      out_col_q;
	logic                  out_last_q;

	logic cfg_wr;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= SIZE_W'(1);
			inner_q <= SIZE_W'(1);
			cols_q  <= SIZE_W'(1);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_ROWS:  rows_q  <= pwdata[SIZE_W-1:0];
				REG_INNER: inner_q <= pwdata[SIZE_W-1:0];
				REG_COLS:  cols_q  <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ROWS:  prdata = PDATA_W'(rows_q);
			REG_INNER: prdata = PDATA_W'(inner_q);
			REG_COLS:  prdata = PDATA_W'(cols_q);
			default:   prdata = '0;
		endcase
	end

	assign m_eff  = clamp_size(rows_q, MAX_ROWS);
	assign n_eff  = clamp_size(inner_q, MAX_INNER);
	assign p_eff  = clamp_size(cols_q, MAX_COLS);
	assign size_a = CNT_W'(m_eff) * CNT_W'(n_eff);
	assign size_b = CNT_W'(n_eff) * CNT_W'(p_eff);

	// input decode
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign in_op         = op_t'(s_axis_tuser);
	assign in_idx        = s_axis_tdata[IDX_W-1:0];
	assign in_val        = s_axis_tdata[IDX_W+VAL_W-1:IDX_W];
	assign load_a_ok     = in_xfer && (in_op == OP_LOAD_A) && (CNT_W'(in_idx) < size_a);
	assign load_b_ok     = in_xfer && (in_op == OP_LOAD_B) && (CNT_W'(in_idx) < size_b);

	// element stores
	always_ff @(posedge clk) begin
		if (load_a_ok) begin
			mem_a[in_idx[AW_A-1:0]] <= in_val[ELEM_WIDTH-1:0];
		end
		if (load_b_ok) begin
			mem_b[in_idx[AW_B-1:0]] <= in_val[ELEM_WIDTH-1:0];
		end
		if (state_q == ST_ISSUE) begin
			a_rd_s1 <= mem_a[a_addr_q[AW_A-1:0]];
			b_rd_s1 <= mem_b[b_addr_q[AW_B-1:0]];
		end
	end

	assign k_last = (k_q == n_eff - SIZE_W'(1));
	assign j_last = (j_q == p_eff - SIZE_W'(1));
	assign i_last = (i_q == m_eff - SIZE_W'(1));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ctl_s1      <= '0;
			out_valid_q <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			a_base_q    <= '0;
			a_addr_q    <= '0;
			b_addr_q    <= '0;
		end else begin
			ctl_s1.valid <= (state_q == ST_ISSUE);
			ctl_s1.first <= (state_q == ST_ISSUE) && (k_q == '0);
			ctl_s1.last  <= (state_q == ST_ISSUE) && k_last;
			if (state_q == ST_DRAIN && mac_done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && in_op == OP_START) begin
						i_q      <= '0;
						j_q      <= '0;
						a_base_q <= '0;
						state_q  <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (!out_valid_q || m_axis_tready) begin
						a_addr_q <= a_base_q;
						b_addr_q <= CNT_W'(j_q);
						k_q      <= '0;
						state_q  <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					a_addr_q <= a_addr_q + CNT_W'(1);
					b_addr_q <= b_addr_q + CNT_W'(p_eff);
					k_q      <= k_q + SIZE_W'(1);
					if (k_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (mac_done) begin
						if (i_last && j_last) begin
							state_q <= ST_IDLE;
						end else begin
							if (j_last) begin
								j_q      <= '0;
								i_q      <= i_q + SIZE_W'(1);
								a_base_q <= a_base_q + CNT_W'(n_eff);
							end else begin
								j_q <= j_q + SIZE_W'(1);
							end
							state_q <= ST_HOLD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	imm_mac #(
		.ELEM_WIDTH(ELEM_WIDTH)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl_s1(ctl_s1),
		.a_s1  (a_rd_s1),
		.b_s1  (b_rd_s1),
		.acc   (mac_acc),
		.done  (mac_done)
	);

	// output register
	always_ff @(posedge clk) begin
		if (state_q == ST_DRAIN && mac_done) begin
			out_value_q <= mac_acc;
			out_row_q   <= i_q[ROW_W-1:0];
			out_col_q   <= j_q[COL_W-1:0];
			out_last_q  <= i_last && j_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {
		(M_DATA_W - VAL_W - ROW_W - COL_W)'(0),
		out_col_q,
		out_row_q,
		VAL_W'(out_value_q)
	};

	// a finished sum only ever lands while the sequencer waits for it
	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> state_q == ST_DRAIN)
		else $error("result finished outside drain");

	// a finished sum never overwrites an untaken result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> !out_valid_q)
		else $error("output register overwritten");

	// input is held off while elements are issued and while a sum drains
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE || state_q == ST_DRAIN) |-> !s_axis_tready)
		else $error("input accepted during run");

endmodule

`default_nettype wire

// ----- test/tb_integer_matrix_multiply.sv -----
// self-checking testbench for the integer matrix multiply block
`timescale 1ns / 1ps

module tb_integer_matrix_multiply;

	import imm_pkg::*;

	localparam int ITEM_TARGET = 380;
	localparam int IDLE_CYCLES = 16;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} product_t;

	class product_board;
		logic [VAL_W-1:0]  elems_a[IDX_SPACE];
		logic [VAL_W-1:0]  elems_b[IDX_SPACE];
		bit                written_a[IDX_SPACE];
		bit                written_b[IDX_SPACE];
		logic [SIZE_W-1:0] size_reg[3];
		product_t          awaited[$];
		int                errors;
		int                results;
		int                starts;

		function new();
			size_reg = '{4'd1, 4'd1, 4'd1};
			errors = 0;
			results = 0;
			starts = 0;
		endfunction

		function int eff_size(logic [1:0] sel);
			int lim;
			int v;
			lim = (sel == REG_ROWS) ? MAX_ROWS_DEF :
				(sel == REG_INNER) ? MAX_INNER_DEF : MAX_COLS_DEF;
			v = size_reg[sel];
			if (v == 0) begin
				return 1;
			end
			return (v > lim) ? lim : v;
		endfunction

		// returns 1 when the item changes state or causes results
		function bit note_input(op_t op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
			int m;
			int n;
			int p;
			logic [VAL_W-1:0] acc;
			product_t r;
			m = eff_size(REG_ROWS);
			n = eff_size(REG_INNER);
			p = eff_size(REG_COLS);
			case (op)
				OP_LOAD_A: begin
					if (idx >= m * n) begin
						return 0;
					end
					elems_a[idx] = val;
					written_a[idx] = 1;
					return 1;
				end
				OP_LOAD_B: begin
					if (idx >= n * p) begin
						return 0;
					end
					elems_b[idx] = val;
					written_b[idx] = 1;
					return 1;
				end
				OP_START: begin
					starts++;
					for (int i = 0; i < m; i++) begin
						for (int j = 0; j < p; j++) begin
							acc = '0;
							for (int k = 0; k < n; k++) begin
								acc = acc + elems_a[i * n + k] * elems_b[k * p + j];
							end
							r.value = acc;
							r.row = ROW_W'(i);
							r.col = COL_W'(j);
							r.last = (i == m - 1) && (j == p - 1);
							awaited.insert(awaited.size(), r);
						end
					end
					return 1;
				end
				default: return 0;
			endcase
		endfunction

		function void check_product(logic [VAL_W-1:0] value, logic [ROW_W-1:0] row,
				logic [COL_W-1:0] col, logic last);
			product_t want;
			results++;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected product transfer value %h row %0d col %0d",
					$time, value, row, col);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (value !== want.value) begin
				$display("%0t: C[%0d][%0d] value expected %h actual %h",
					$time, want.row, want.col, want.value, value);
				errors++;
			end
			if (row !== want.row) begin
				$display("%0t: row expected %0d actual %0d", $time, want.row, row);
				errors++;
			end
			if (col !== want.col) begin
				$display("%0t: col expected %0d actual %0d", $time, want.col, col);
				errors++;
			end
			if (last !== want.last) begin
				$display("%0t: C[%0d][%0d] last expected %b actual %b",
					$time, want.row, want.col, want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_DATA_W-1:0]  s_axis_tdata = '0;
	logic [OP_W-1:0]      s_axis_tuser = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0]  m_axis_tdata;
	logic                 m_axis_tlast;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [PDATA_W-1:0]   pwdata = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	product_board board;
	bit                   steady = 1'b0;
	int                   out_stall = 0;
	int                   out_gap;
	int                   useful_items = 0;
	int                   reg_writes = 0;

	integer_matrix_multiply dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #1 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [VAL_W-1:0] rand_value();
		case ($urandom_range(0, 11))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(0, 9))
			0: return 4'd0;
			1: return SIZE_W'($urandom_range(9, 15));
			2, 3: return SIZE_W'($urandom_range(5, 8));
			default: return SIZE_W'($urandom_range(1, 4));
		endcase
	endfunction

	// result side: check every transfer, stall at random unless steady
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			board.check_product(m_axis_tdata[31:0], m_axis_tdata[34:32],
				m_axis_tdata[37:35], m_axis_tlast);
		end
		if (out_stall > 0) begin
			out_stall = out_stall - 1;
			m_axis_tready <= 1'b0;
		end else begin
			out_gap = steady ? 0 : pick_gap();
			if (out_gap > 0) begin
				out_stall = out_gap - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// leaves tvalid high; the caller lowers it or sends the next item
	task automatic send_item(input op_t op, input logic [IDX_W-1:0] idx,
			input logic [VAL_W-1:0] val);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {2'b00, val, idx};
		do @(posedge clk); while (!s_axis_tready);
		if (board.note_input(op, idx, val)) begin
			useful_items++;
		end
	endtask

	task automatic hold_input();
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (board.awaited.size() != 0) @(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [1:0] sel, input logic [SIZE_W-1:0] raw);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= ($urandom_range(0, 2) == 0) ? {28'($urandom()), raw} : {28'd0, raw};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		board.size_reg[sel] = raw;
		reg_writes++;
	endtask

	task automatic reg_check(input logic [1:0] sel);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {sel, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {28'd0, board.size_reg[sel]}) begin
			$display("%0t: register %0d read expected %h actual %h",
				$time, sel, {28'd0, board.size_reg[sel]}, prdata);
			board.errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_sizes(input logic [SIZE_W-1:0] r, input logic [SIZE_W-1:0] n,
			input logic [SIZE_W-1:0] p);
		int first;
		logic [1:0] sel;
		first = $urandom_range(0, 2);
		for (int k = 0; k < 3; k++) begin
			sel = 2'((first + k) % 3);
			case (sel)
				REG_ROWS: reg_write(REG_ROWS, r);
				REG_INNER: reg_write(REG_INNER, n);
				default: reg_write(REG_COLS, p);
			endcase
			reg_check(sel);
		end
	endtask

	// stores are undefined until written, so cover every entry the next start reads
	task automatic fill_missing();
		int na;
		int nb;
		na = board.eff_size(REG_ROWS) * board.eff_size(REG_INNER);
		nb = board.eff_size(REG_INNER) * board.eff_size(REG_COLS);
		for (int i = 0; i < na; i++) begin
			if (!board.written_a[i]) begin
				send_item(OP_LOAD_A, IDX_W'(i), rand_value());
			end
		end
		for (int i = 0; i < nb; i++) begin
			if (!board.written_b[i]) begin
				send_item(OP_LOAD_B, IDX_W'(i), rand_value());
			end
		end
	endtask

	task automatic send_noise();
		int na;
		int nb;
		na = board.eff_size(REG_ROWS) * board.eff_size(REG_INNER);
		nb = board.eff_size(REG_INNER) * board.eff_size(REG_COLS);
		case ($urandom_range(0, 2))
			0: send_item(OP_NONE, IDX_W'($urandom()), $urandom());
			1: begin
				if (na < IDX_SPACE) begin
					send_item(OP_LOAD_A, IDX_W'($urandom_range(na, IDX_SPACE - 1)), $urandom());
				end else begin
					send_item(OP_NONE, IDX_W'($urandom()), $urandom());
				end
			end
			default: begin
				if (nb < IDX_SPACE) begin
					send_item(OP_LOAD_B, IDX_W'($urandom_range(nb, IDX_SPACE - 1)), $urandom());
				end else begin
					send_item(OP_NONE, IDX_W'($urandom()), $urandom());
				end
			end
		endcase
	endtask

	// whole A and B in a shuffled, interleaved order, with occasional ignored items
	task automatic load_all();
		int order[$];
		int na;
		int nb;
		int j;
		int tmp;
		na = board.eff_size(REG_ROWS) * board.eff_size(REG_INNER);
		nb = board.eff_size(REG_INNER) * board.eff_size(REG_COLS);
		for (int i = 0; i < na; i++) order.insert(order.size(), i);
		for (int i = 0; i < nb; i++) order.insert(order.size(), IDX_SPACE + i);
		for (int i = order.size() - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		foreach (order[i]) begin
			if ($urandom_range(0, 9) == 0) begin
				send_noise();
			end
			if (order[i] < IDX_SPACE) begin
				send_item(OP_LOAD_A, IDX_W'(order[i]), rand_value());
			end else begin
				send_item(OP_LOAD_B, IDX_W'(order[i] - IDX_SPACE), rand_value());
			end
		end
	endtask

	task automatic load_some();
		int cnt;
		int na;
		int nb;
		na = board.eff_size(REG_ROWS) * board.eff_size(REG_INNER);
		nb = board.eff_size(REG_INNER) * board.eff_size(REG_COLS);
		cnt = $urandom_range(0, 6);
		for (int i = 0; i < cnt; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				send_noise();
			end else if ($urandom_range(0, 1) == 0) begin
				send_item(OP_LOAD_A, IDX_W'($urandom_range(0, na - 1)), rand_value());
			end else begin
				send_item(OP_LOAD_B, IDX_W'($urandom_range(0, nb - 1)), rand_value());
			end
		end
	endtask

	initial begin
		int phase;
		int reps;
		board = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes, wrap of the largest product, ignored items
		reg_check(REG_ROWS);
		reg_check(REG_INNER);
		reg_check(REG_COLS);
		send_item(OP_LOAD_A, 6'd0, 32'hFFFF_FFFF);
		send_item(OP_LOAD_B, 6'd0, 32'hFFFF_FFFF);
		send_item(OP_START, 6'd0, 32'h0000_0000);
		send_item(OP_LOAD_A, 6'd1, 32'h1234_5678);
		send_item(OP_LOAD_B, 6'd63, 32'hFFFF_FFFF);
		send_item(OP_LOAD_A, 6'd63, 32'h0000_0000);
		send_item(OP_NONE, 6'd63, 32'hFFFF_FFFF);
		send_item(OP_START, 6'd63, 32'hFFFF_FFFF);
		hold_input();
		wait_idle();

		// clamped sizes: rows above max, inner zero
		set_sizes(4'd15, 4'd0, 4'd1);
		send_item(OP_LOAD_A, 6'd0, 32'h8000_0000);
		fill_missing();
		send_item(OP_START, 6'd0, 32'h0000_0000);
		hold_input();
		wait_idle();

		// sizes changed after loading: flat contents reused
		set_sizes(4'd2, 4'd2, 4'd2);
		fill_missing();
		send_item(OP_START, 6'd0, 32'h0000_0000);
		hold_input();
		wait_idle();

		phase = 0;
		while (useful_items < ITEM_TARGET) begin
			if (phase == 0) begin
				set_sizes(4'd8, 4'd8, 4'd8);
			end else if (phase == 1) begin
				set_sizes(4'd0, 4'd1, 4'd0);
			end else begin
				set_sizes(pick_size(), pick_size(), pick_size());
			end
			steady = ($urandom_range(0, 3) == 0);
			reps = $urandom_range(1, 3);
			for (int r = 0; r < reps; r++) begin
				if (r == 0) begin
					load_all();
				end else begin
					load_some();
				end
				fill_missing();
				send_item(OP_START, IDX_W'($urandom()), $urandom());
				if ($urandom_range(0, 3) == 0) begin
					hold_input();
					do @(posedge clk); while (board.awaited.size() != 0);
				end
			end
			hold_input();
			wait_idle();
			phase++;
		end
		steady = 1'b0;

		repeat (IDLE_CYCLES) @(posedge clk);
		$display("Run covered %0d effective items in %0d size settings, %0d register writes,",
			useful_items, phase + 3, reg_writes);
		$display("%0d multiplies and %0d product transfers checked, %0d errors",
			board.starts, board.results, board.errors);
		if (board.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Timeout with %0d products outstanding", board.awaited.size());
		$display("Verification failed");
		$finish;
	end

endmodule
